// File: sv/circular_list_engine_top_defines.svh
// Assertion macros shared by the circular list engine RTL.
// Depends on nothing; included by circular_list_engine_top.
`ifndef CIRCULAR_LIST_ENGINE_TOP_DEFINES_SVH
`define CIRCULAR_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLIST_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("circular list engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLIST_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("circular list engine: next-cycle check failed");

`endif

// File: sv/clist_pkg.sv
// Shared types and constants of the circular list engine.
// Depends on nothing; imported by every module of the block.
package clist_pkg;

  localparam int DefCapacity = 16;
  localparam int ValueW      = 32;
  localparam int CmdW        = 3;
  localparam int StatusW     = 3;
  localparam int CountOutW   = 5;

  // Command codes carried by a command word.
  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_TRAVERSE  = 3'd6
  } cmd_e;

  // Status codes returned with each result word.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NEG_POS   = 3'd2,
    ST_OUT_RANGE = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

endpackage

// File: sv/clist_mod.sv
// Iterative remainder unit: one restoring compare-subtract step per cycle.
// Depends on clist_pkg for the operand width.
module clist_mod #(
  parameter int CountW = 5,
  parameter int AddrW  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [clist_pkg::ValueW-1:0] dividend_i,
  input  logic [CountW-1:0]          divisor_i,
  output logic                       done_o,
  output logic [AddrW-1:0]           rem_o
);
  import clist_pkg::*;

  localparam int StepW = $clog2(ValueW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [ValueW-1:0] dvd_q, dvd_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW:0]   trial;

  // One dividend bit per cycle, most significant dividend bit first.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[ValueW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d  = trial[CountW-1:0];
      dvd_d  = {dvd_q[ValueW-2:0], 1'b0};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[AddrW-1:0];

endmodule

// File: sv/clist_store.sv
// Element memory: one write port and one registered read port.
// Depends on clist_pkg for the element width.
module clist_store #(
  parameter int Capacity = 16,
  parameter int AddrW    = 4
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [clist_pkg::ValueW-1:0] wdata_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [clist_pkg::ValueW-1:0] rdata_o
);
  import clist_pkg::*;

  logic [ValueW-1:0] mem_q [Capacity];
  logic [ValueW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/circular_list_engine_top.sv
// Circular list engine top level: command sequencer over the element memory
// and the shared remainder unit. Depends on clist_pkg, clist_mod, clist_store
// and circular_list_engine_top_defines.svh.
//
// Usage: drive command_i, value_i and position_i with start_i high; the word
// is taken at a clock edge where busy_o is low. Each result word appears on
// element_value_o, status_o, last_result_o and element_count_o for exactly one
// cycle with result_valid_o high; the receiver cannot stall it.
// Every command but traverse and code 7 answers with one word marked last_result_o.
// Traverse answers with one word per element (or one empty-status word).
// A rejected command answers in the cycle after it is taken. Insert and delete
// move the tail one entry at a time, through a check, a read and a write state
// per entry; positional commands first wait for the bit-serial remainder unit.
// Traverse alternates a read state and an output state for each word, set by
// the registered read port of the element memory. Command code 7 is dropped
// without a result. Reset empties the list; memory contents are not cleared
// and are only read below the element count.
module circular_list_engine_top #(
  parameter int CAPACITY = clist_pkg::DefCapacity
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [clist_pkg::CmdW-1:0]      command_i,
  input  logic signed [clist_pkg::ValueW-1:0] value_i,
  input  logic signed [clist_pkg::ValueW-1:0] position_i,
  output logic                            result_valid_o,
  output logic signed [clist_pkg::ValueW-1:0] element_value_o,
  output logic [clist_pkg::StatusW-1:0]   status_o,
  output logic                            last_result_o,
  output logic [clist_pkg::CountOutW-1:0] element_count_o
);
  import clist_pkg::*;

  `include "circular_list_engine_top_defines.svh"

  localparam int AddrW  = $clog2(CAPACITY);
  localparam int CountW = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MOD    = 4'd1;
  localparam logic [3:0] S_INS    = 4'd2;
  localparam logic [3:0] S_SHR_RD = 4'd3;
  localparam logic [3:0] S_SHR_WR = 4'd4;
  localparam logic [3:0] S_PUT    = 4'd5;
  localparam logic [3:0] S_DEL    = 4'd6;
  localparam logic [3:0] S_SHL_RD = 4'd7;
  localparam logic [3:0] S_SHL_WR = 4'd8;
  localparam logic [3:0] S_TRV_RD = 4'd9;
  localparam logic [3:0] S_TRV_OUT = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] ptr_q, ptr_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              ins_q, ins_d;
  logic [ValueW-1:0] val_q, val_d;

  logic                 res_valid_q, res_valid_d;
  logic [ValueW-1:0]    res_value_q, res_value_d;
  logic [StatusW-1:0]   res_status_q, res_status_d;
  logic                 res_last_q, res_last_d;
  logic [CountOutW-1:0] res_count_q, res_count_d;

  logic              mod_start;
  logic [ValueW-1:0] mod_dividend;
  logic              mod_done;
  logic [AddrW-1:0]  mod_rem;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [ValueW-1:0] mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [ValueW-1:0] mem_rdata;

  logic              full;
  logic              empty;
  logic [CountW-1:0] ptr_dec;
  logic [CountW-1:0] ptr_inc;

  assign full    = (count_q == CountW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign ptr_dec = ptr_q - CountW'(1);
  assign ptr_inc = ptr_q + CountW'(1);

  // Command sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    idx_d        = idx_q;
    ins_d        = ins_q;
    val_d        = val_q;
    res_valid_d  = 1'b0;
    res_value_d  = '0;
    res_status_d = ST_OK;
    res_last_d   = 1'b1;
    mod_start    = 1'b0;
    mod_dividend = position_i;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AddrW-1:0];
    mem_wdata    = val_q;
    mem_raddr    = ptr_q[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = value_i;
          case (command_i)
            CMD_INS_FRONT, CMD_INS_END: begin
              if (full) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else begin
                idx_d   = (command_i == CMD_INS_FRONT) ? '0 : count_q;
                ptr_d   = count_q;
                state_d = S_INS;
              end
            end
            CMD_INS_POS: begin
              if (position_i[ValueW-1]) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_NEG_POS;
              end else if (full) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else if (position_i == '0) begin
                idx_d   = '0;
                ptr_d   = count_q;
                state_d = S_INS;
              end else if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_OUT_RANGE;
              end else begin
                mod_start    = 1'b1;
                mod_dividend = position_i - ValueW'(1);
                ins_d        = 1'b1;
                state_d      = S_MOD;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_END: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                idx_d   = (command_i == CMD_DEL_FRONT) ? '0 : count_q - CountW'(1);
                ptr_d   = (command_i == CMD_DEL_FRONT) ? '0 : count_q - CountW'(1);
                state_d = S_DEL;
              end
            end
            CMD_DEL_POS: begin
              if (position_i[ValueW-1]) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_NEG_POS;
              end else if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                mod_start = 1'b1;
                ins_d     = 1'b0;
                state_d   = S_MOD;
              end
            end
            CMD_TRAVERSE: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = S_TRV_RD;
              end
            end
            default: begin
              // The unused command code is dropped without a result.
            end
          endcase
        end
      end

      // Wait for the wrapped position.
      S_MOD: begin
        if (mod_done) begin
          if (ins_q) begin
            idx_d   = CountW'(mod_rem) + CountW'(1);
            ptr_d   = count_q;
            state_d = S_INS;
          end else begin
            idx_d   = CountW'(mod_rem);
            ptr_d   = CountW'(mod_rem);
            state_d = S_DEL;
          end
        end
      end

      // Open a gap at the target index, moving the tail up one entry at a time.
      S_INS: begin
        state_d = (ptr_q > idx_q) ? S_SHR_RD : S_PUT;
      end
      S_SHR_RD: begin
        mem_raddr = ptr_dec[AddrW-1:0];
        state_d   = S_SHR_WR;
      end
      S_SHR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AddrW-1:0];
        mem_wdata = mem_rdata;
        ptr_d     = ptr_dec;
        state_d   = S_INS;
      end
      S_PUT: begin
        mem_we      = 1'b1;
        count_d     = count_q + CountW'(1);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      // Close the gap at the target index, moving the tail down.
      S_DEL: begin
        if (ptr_inc < count_q) begin
          state_d = S_SHL_RD;
        end else begin
          count_d     = count_q - CountW'(1);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SHL_RD: begin
        mem_raddr = ptr_inc[AddrW-1:0];
        state_d   = S_SHL_WR;
      end
      S_SHL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AddrW-1:0];
        mem_wdata = mem_rdata;
        ptr_d     = ptr_inc;
        state_d   = S_DEL;
      end

      // Read each element and emit it the following cycle.
      S_TRV_RD: begin
        state_d = S_TRV_OUT;
      end
      S_TRV_OUT: begin
        res_valid_d = 1'b1;
        res_value_d = mem_rdata;
        res_last_d  = (ptr_inc == count_q);
        ptr_d       = ptr_inc;
        state_d     = (ptr_inc == count_q) ? S_IDLE : S_TRV_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_count_d = CountOutW'(count_d);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    idx_q        <= idx_d;
    ins_q        <= ins_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    res_count_q  <= res_count_d;
  end

  clist_mod #(
    .CountW (CountW),
    .AddrW  (AddrW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  clist_store #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy_o          = (state_q != S_IDLE);
  assign result_valid_o  = res_valid_q;
  assign element_value_o = res_value_q;
  assign status_o        = res_status_q;
  assign last_result_o   = res_last_q;
  assign element_count_o = res_count_q;

  // The element count never passes the capacity.
  `CLIST_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CountW'(CAPACITY))
  // A word that is not the last one of a traverse leaves the sequencer busy.
  `CLIST_ASSERT_NOW(a_more_words, clk_i, rst_ni, result_valid_o && !last_result_o, busy_o)
  // A traverse taken on an idle block answers or starts reading at once.
  `CLIST_ASSERT_NEXT(a_trv_starts, clk_i, rst_ni,
    start_i && !busy_o && (command_i == CMD_TRAVERSE), busy_o || result_valid_o)
  // A list-full answer leaves the count where it was.
  `CLIST_ASSERT_NOW(a_full_keeps, clk_i, rst_ni,
    result_valid_o && (status_o == ST_FULL), $stable(count_q))

endmodule

// File: test/circular_list_checker.sv
// Checker for the circular list engine: tracks the list contents, predicts the
// result words of every accepted command word and compares them as they come.
// Depends on clist_pkg.
module circular_list_checker
  import clist_pkg::*;
#(
  parameter int CAPACITY = clist_pkg::DefCapacity
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [CmdW-1:0]          command_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic signed [ValueW-1:0] position_i,
  input  logic                     result_valid_i,
  input  logic signed [ValueW-1:0] element_value_i,
  input  logic [StatusW-1:0]       status_i,
  input  logic                     last_result_i,
  input  logic [CountOutW-1:0]     element_count_i,
  output int                       mismatch_count_o,
  output int                       pending_count_o,
  output int                       accepted_count_o,
  output int                       checked_count_o,
  output int                       full_reject_count_o
);

  // One result word as the engine presents it.
  typedef struct packed {
    logic [ValueW-1:0]    value;
    logic [StatusW-1:0]   status;
    logic                 last;
    logic [CountOutW-1:0] count;
  } list_word_t;

  logic [ValueW-1:0] list_mem [CAPACITY];
  int unsigned       list_len;
  list_word_t        expected_words [$];

  // Queue one expected word; the count field shows the length after the command.
  function automatic void push_word(logic [ValueW-1:0] val, logic [StatusW-1:0] st,
                                    logic last);
    list_word_t w;
    w.value  = val;
    w.status = st;
    w.last   = last;
    w.count  = CountOutW'(list_len);
    expected_words.push_back(w);
  endfunction

  // Open a slot at idx by shifting the tail up; the caller makes sure there is room.
  function automatic void insert_entry(int unsigned idx, logic [ValueW-1:0] val);
    int unsigned i;
    for (i = list_len; i > idx; i--) begin
      list_mem[i] = list_mem[i - 1];
    end
    list_mem[idx] = val;
    list_len++;
  endfunction

  // Close the slot at idx by shifting the tail down.
  function automatic void remove_entry(int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < list_len; i++) begin
      list_mem[i] = list_mem[i + 1];
    end
    list_len--;
  endfunction

  // Apply one command word to the tracked list and queue the words it should produce.
  function automatic void apply_command(logic [CmdW-1:0] cmd, logic [ValueW-1:0] val,
                                        logic [ValueW-1:0] pos);
    logic [StatusW-1:0] st;
    int unsigned        i;
    st = ST_OK;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_END: begin
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          insert_entry((cmd == CMD_INS_FRONT) ? 0 : list_len, val);
        end
      end
      CMD_INS_POS: begin
        // A negative position is rejected before the list is even looked at.
        if (pos[ValueW-1]) begin
          st = ST_NEG_POS;
        end else if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else if (pos == '0) begin
          insert_entry(0, val);
        end else if (list_len == 0) begin
          st = ST_OUT_RANGE;
        end else begin
          insert_entry(((pos - 1) % list_len) + 1, val);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_END: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          remove_entry((cmd == CMD_DEL_FRONT) ? 0 : list_len - 1);
        end
      end
      CMD_DEL_POS: begin
        if (pos[ValueW-1]) begin
          st = ST_NEG_POS;
        end else if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          remove_entry(pos % list_len);
        end
      end
      CMD_TRAVERSE: begin
        // An empty list answers with a single empty-status word.
        if (list_len == 0) begin
          push_word('0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) begin
            push_word(list_mem[i], ST_OK, (i + 1 == list_len));
          end
        end
        return;
      end
      default: begin
        // The unused code is dropped without a word.
        return;
      end
    endcase
    if (st == ST_FULL) begin
      full_reject_count_o++;
    end
    push_word('0, st, 1'b1);
  endfunction

  function automatic void report_failure(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Compare result words first, then take in the command word of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    list_word_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_words.delete();
      pending_count_o = 0;
    end else begin
      if (result_valid_i) begin
        checked_count_o++;
        if (expected_words.size() == 0) begin
          report_failure($sformatf("unexpected word: value %h status %0d last %0b count %0d",
                                   element_value_i, status_i, last_result_i,
                                   element_count_i));
        end else begin
          want = expected_words.pop_front();
          if (element_value_i !== want.value || status_i !== want.status ||
              last_result_i !== want.last || element_count_i !== want.count) begin
            report_failure($sformatf(
              "word mismatch: value %h/%h status %0d/%0d last %0b/%0b count %0d/%0d (exp/act)",
              want.value, element_value_i, want.status, status_i, want.last,
              last_result_i, want.count, element_count_i));
          end
        end
      end
      if (start_i && !busy_i) begin
        accepted_count_o++;
        apply_command(command_i, value_i, position_i);
      end
      pending_count_o = expected_words.size();
    end
  end

endmodule

// File: test/circular_list_engine_top_test.sv
// Testbench top for the circular list engine: drives directed and random command
// words and gives the verdict. Depends on clist_pkg, circular_list_engine_top and
// circular_list_checker.
module circular_list_engine_top_test;
  import clist_pkg::*;

  localparam int CAPACITY     = DefCapacity;
  localparam int RANDOM_WORDS = 220;
  localparam int MAX_GAP      = 20;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 100;
  localparam logic [CmdW-1:0] CMD_UNUSED = 3'd7;

  typedef enum int {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_MIXED
  } mood_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [CmdW-1:0]          command_i;
  logic signed [ValueW-1:0] value_i;
  logic signed [ValueW-1:0] position_i;
  logic                     result_valid_o;
  logic signed [ValueW-1:0] element_value_o;
  logic [StatusW-1:0]       status_o;
  logic                     last_result_o;
  logic [CountOutW-1:0]     element_count_o;

  int mismatch_total;
  int pending_words;
  int accepted_words;
  int checked_words;
  int full_rejects;

  // Free-running clock, period 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  circular_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .element_value_o(element_value_o),
    .status_o       (status_o),
    .last_result_o  (last_result_o),
    .element_count_o(element_count_o)
  );

  circular_list_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .command_i          (command_i),
    .value_i            (value_i),
    .position_i         (position_i),
    .result_valid_i     (result_valid_o),
    .element_value_i    (element_value_o),
    .status_i           (status_o),
    .last_result_i      (last_result_o),
    .element_count_i    (element_count_o),
    .mismatch_count_o   (mismatch_total),
    .pending_count_o    (pending_words),
    .accepted_count_o   (accepted_words),
    .checked_count_o    (checked_words),
    .full_reject_count_o(full_rejects)
  );

  // Present one command word from a falling edge and hold it until it is taken.
  // Start stays high afterwards; the caller lowers it for a gap and at the end.
  task automatic send_command(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val,
                              input logic [ValueW-1:0] pos);
    start_i    <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int               phase_idle [3];
    mood_e            mood;
    int               burst_left;
    int               sent;
    int               gap;
    int unsigned      r;
    logic [CmdW-1:0]  cmd;
    logic [ValueW-1:0] val;
    logic [ValueW-1:0] pos;

    phase_idle = '{16, 65, 0};
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    command_i  = '0;
    value_i    = '0;
    position_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: rejections on an empty list, the ignored code, a one-element
    // positional delete, extreme values and positions, and wrapped positions.
    send_command(CMD_TRAVERSE,  '0, '0);
    send_command(CMD_DEL_FRONT, '0, '0);
    send_command(CMD_DEL_END,   '0, '0);
    send_command(CMD_DEL_POS,   '0, 32'd3);
    send_command(CMD_DEL_POS,   '0, 32'hffff_ffff);
    send_command(CMD_INS_POS,   32'd5, 32'd5);
    send_command(CMD_INS_POS,   32'd6, 32'h8000_0000);
    send_command(CMD_UNUSED,    '1, '1);
    send_command(CMD_INS_POS,   32'h7fff_ffff, '0);
    send_command(CMD_DEL_POS,   '0, 32'd9);
    send_command(CMD_INS_FRONT, 32'h8000_0000, '0);
    send_command(CMD_INS_END,   32'hffff_ffff, '0);
    send_command(CMD_INS_FRONT, '0, '0);
    send_command(CMD_INS_POS,   32'h5555_5555, 32'h7fff_ffff);
    send_command(CMD_INS_POS,   32'haaaa_aaaa, 32'd1);
    send_command(CMD_TRAVERSE,  '0, '0);
    send_command(CMD_DEL_POS,   '0, 32'h7fff_ffff);
    send_command(CMD_DEL_POS,   '0, '0);
    send_command(CMD_DEL_END,   '0, '0);
    send_command(CMD_DEL_FRONT, '0, '0);
    send_command(CMD_TRAVERSE,  '0, '0);

    // Random: bursts that fill, drain or mix, so the list swings between empty
    // and full. The first burst fills. Sender gaps are rare, then frequent, then absent.
    mood       = MOOD_FILL;
    burst_left = 30;
    sent       = 0;
    while (sent < RANDOM_WORDS) begin
      if (burst_left == 0) begin
        r          = $urandom_range(9);
        mood       = (r < 4) ? MOOD_FILL : (r < 7) ? MOOD_DRAIN : MOOD_MIXED;
        burst_left = $urandom_range(10, 30);
      end
      burst_left--;

      // Sender gap with junk on the fields while start is low.
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < phase_idle[sent * 3 / RANDOM_WORDS]) begin
        start_i    <= 1'b0;
        command_i  <= CmdW'($urandom);
        value_i    <= $urandom;
        position_i <= $urandom;
        @(negedge clk_i);
        gap++;
      end

      r = $urandom_range(99);
      case (mood)
        MOOD_FILL: begin
          cmd = (r < 30) ? CMD_INS_FRONT : (r < 55) ? CMD_INS_END :
                (r < 80) ? CMD_INS_POS : (r < 88) ? CMD_TRAVERSE : CmdW'($urandom_range(7));
        end
        MOOD_DRAIN: begin
          cmd = (r < 25) ? CMD_DEL_FRONT : (r < 50) ? CMD_DEL_END :
                (r < 80) ? CMD_DEL_POS : (r < 90) ? CMD_TRAVERSE : CmdW'($urandom_range(7));
        end
        default: begin
          cmd = CmdW'($urandom_range(7));
        end
      endcase

      if ($urandom_range(99) < 80) begin
        val = $urandom;
      end else begin
        case ($urandom_range(3))
          0:       val = 32'h7fff_ffff;
          1:       val = 32'h8000_0000;
          2:       val = '1;
          default: val = '0;
        endcase
      end

      // Mostly small positions that wrap a few times; also huge and negative ones.
      r = $urandom_range(99);
      if (r < 55) begin
        pos = $urandom_range(2 * CAPACITY);
      end else if (r < 70) begin
        pos = $urandom;
      end else if (r < 80) begin
        pos = $urandom & 32'h7fff_ffff;
      end else if (r < 85) begin
        pos = 32'h7fff_ffff;
      end else if (r < 90) begin
        pos = 32'h8000_0000;
      end else if (r < 95) begin
        pos = '1;
      end else begin
        pos = '0;
      end

      send_command(cmd, val, pos);
      if (cmd != CMD_UNUSED) begin
        sent++;
      end
    end
    start_i <= 1'b0;

    // Drain outstanding words, then watch a while longer for stray ones.
    while (pending_words != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d command words over three idle phases and %0d result words.",
             accepted_words, checked_words);
    $display("Coverage: %0d inserts met a full list; %0d failures counted.",
             full_rejects, mismatch_total);
    if (mismatch_total == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: too many cycles in a row with no word taken in or out ends the run.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (start_i && !busy_o) || result_valid_o) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/clist_pkg.sv
sv/clist_mod.sv
sv/clist_store.sv
sv/circular_list_engine_top.sv
test/circular_list_checker.sv
test/circular_list_engine_top_test.sv
